/* rtl/kmh_pkg.sv */
package kmh_pkg;

    localparam int KEY_W = 32;
    localparam int SRC_W = 6;
    localparam int LEFT_W = 7;
    localparam int DEF_MAX_LISTS = 64;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_BUILD = 2'd1;
    localparam logic [1:0] ACT_REPLACE = 2'd2;
    localparam logic [1:0] ACT_REMOVE = 2'd3;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [SRC_W-1:0] src;
    } entry_t;

    typedef struct packed {
        logic load;
        logic signed [KEY_W-1:0] value;
        logic [SRC_W-1:0] list;
        logic [LEFT_W-1:0] left;
        logic err;
    } result_t;

endpackage

/* rtl/kway_merge_min_heap.sv */
// k-way merge min-heap: load list heads (action 0), build the heap (action 1), then
// pop with replace (2) or remove (3); each pop returns one word with the minimum key,
// its list and the entry count after the pop, or empty_error on an empty heap.
// a load and a build with nothing to order finish in the idle state; a pop reads the root
// and the last word, returns the root, then sinks the replacement word level by level;
// a pop of an empty heap goes straight to the error word. a build sinks each of the
// count/2 inner nodes in turn, from the last one down to the root. the sift loop
// alternates between reading both children from the heap memory and comparing them
// and writing back.
// in_stall is high while an operation is in progress; a finished result waits in the
// output register without holding up later loads.
module kway_merge_min_heap
    import kmh_pkg::*;
#(
    parameter int MAX_LISTS = DEF_MAX_LISTS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               action,
    input  logic signed [KEY_W-1:0]  item_value,
    input  logic [SRC_W-1:0]         item_list,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [KEY_W-1:0]  min_value,
    output logic [SRC_W-1:0]         min_list,
    output logic [LEFT_W-1:0]        entries_left,
    output logic                     empty_error
);

    localparam int AW = $clog2(MAX_LISTS);
    localparam int CW = $clog2(MAX_LISTS + 1);

    logic out_valid_reg, out_valid_next;
    result_t out_reg;
    logic out_free;
    result_t res;

    logic ram_we;
    logic [AW-1:0] ram_waddr;
    entry_t ram_wdata;
    logic ram_re;
    logic [AW-1:0] ram_raddr_a;
    logic [AW-1:0] ram_raddr_b;
    entry_t ram_rdata_a;
    entry_t ram_rdata_b;

    assign out_free = !out_valid_reg || !out_stall;

    kmh_ctrl #(
        .MAX_LISTS(MAX_LISTS),
        .AW(AW),
        .CW(CW)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .action(action),
        .item_value(item_value),
        .item_list(item_list),
        .in_stall(in_stall),
        .out_free(out_free),
        .res(res),
        .ram_we(ram_we),
        .ram_waddr(ram_waddr),
        .ram_wdata(ram_wdata),
        .ram_re(ram_re),
        .ram_raddr_a(ram_raddr_a),
        .ram_raddr_b(ram_raddr_b),
        .ram_rdata_a(ram_rdata_a),
        .ram_rdata_b(ram_rdata_b)
    );

    kmh_ram #(
        .DEPTH(MAX_LISTS),
        .AW(AW)
    ) u_ram (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re(ram_re),
        .raddr_a(ram_raddr_a),
        .raddr_b(ram_raddr_b),
        .rdata_a(ram_rdata_a),
        .rdata_b(ram_rdata_b)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign min_value = out_reg.value;
    assign min_list = out_reg.list;
    assign entries_left = out_reg.left;
    assign empty_error = out_reg.err;

endmodule

/* rtl/kmh_ram.sv */
module kmh_ram
    import kmh_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_LISTS,
    parameter int AW = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output entry_t        rdata_a,
    output entry_t        rdata_b
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

/* rtl/kmh_ctrl.sv */
module kmh_ctrl
    import kmh_pkg::*;
#(
    parameter int MAX_LISTS = DEF_MAX_LISTS,
    parameter int AW = $clog2(MAX_LISTS),
    parameter int CW = $clog2(MAX_LISTS + 1)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [1:0]              action,
    input  logic signed [KEY_W-1:0] item_value,
    input  logic [SRC_W-1:0]        item_list,
    output logic                    in_stall,
    input  logic                    out_free,
    output result_t                 res,
    output logic                    ram_we,
    output logic [AW-1:0]           ram_waddr,
    output entry_t                  ram_wdata,
    output logic                    ram_re,
    output logic [AW-1:0]           ram_raddr_a,
    output logic [AW-1:0]           ram_raddr_b,
    input  entry_t                  ram_rdata_a,
    input  entry_t                  ram_rdata_b
);

    localparam int CHW = AW + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POP_RD = 3'd1;
    localparam logic [2:0] S_POP_DAT = 3'd2;
    localparam logic [2:0] S_ERR = 3'd3;
    localparam logic [2:0] S_BLD_RD = 3'd4;
    localparam logic [2:0] S_BLD_DAT = 3'd5;
    localparam logic [2:0] S_SIFT_RD = 3'd6;
    localparam logic [2:0] S_SIFT_CMP = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] bidx_reg, bidx_next;
    logic build_reg, build_next;
    logic remove_reg, remove_next;
    entry_t cur_reg, cur_next;
    logic signed [KEY_W-1:0] val_reg, val_next;

    logic in_acc;
    logic [CHW-1:0] left_idx;
    logic [CHW-1:0] right_idx;
    logic [CHW-1:0] n_ext;
    logic right_ok;
    logic pick_right;
    entry_t pick;
    logic [AW-1:0] pick_idx;
    logic swap;
    logic [CW-1:0] half;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc = in_valid && !in_stall;

    assign left_idx = (CHW'(pos_reg) << 1) + CHW'(1);
    assign right_idx = left_idx + CHW'(1);
    assign n_ext = CHW'(count_reg);
    assign right_ok = (right_idx < n_ext);
    assign pick_right = right_ok && (ram_rdata_a.key > ram_rdata_b.key);
    assign pick = pick_right ? ram_rdata_b : ram_rdata_a;
    assign pick_idx = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
    assign swap = (cur_reg.key > pick.key);
    assign half = count_reg >> 1;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next = pos_reg;
        bidx_next = bidx_reg;
        build_next = build_reg;
        remove_next = remove_reg;
        cur_next = cur_reg;
        val_next = val_reg;
        ram_we = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = cur_reg;
        ram_re = 1'b0;
        ram_raddr_a = left_idx[AW-1:0];
        ram_raddr_b = right_idx[AW-1:0];
        res = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (action)
                        ACT_LOAD:
                        begin
                            if (count_reg < CW'(MAX_LISTS))
                            begin
                                ram_we = 1'b1;
                                ram_waddr = count_reg[AW-1:0];
                                ram_wdata.key = item_value;
                                ram_wdata.src = item_list;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ACT_BUILD:
                        begin
                            if (half != '0)
                            begin
                                bidx_next = AW'(half - CW'(1));
                                build_next = 1'b1;
                                state_next = S_BLD_RD;
                            end
                        end
                        default:
                        begin
                            val_next = item_value;
                            remove_next = (action == ACT_REMOVE);
                            build_next = 1'b0;
                            state_next = (count_reg == '0) ? S_ERR : S_POP_RD;
                        end
                    endcase
                end
            end
            S_POP_RD:
            begin
                ram_re = 1'b1;
                ram_raddr_a = '0;
                ram_raddr_b = AW'(count_reg - CW'(1));
                state_next = S_POP_DAT;
            end
            S_POP_DAT:
            begin
                if (out_free)
                begin
                    res.load = 1'b1;
                    res.value = ram_rdata_a.key;
                    res.list = ram_rdata_a.src;
                    res.err = 1'b0;
                    pos_next = '0;
                    if (remove_reg)
                    begin
                        count_next = count_reg - CW'(1);
                        cur_next = ram_rdata_b;
                    end
                    else
                    begin
                        cur_next.key = val_reg;
                        cur_next.src = ram_rdata_a.src;
                    end
                    res.left = LEFT_W'(count_next);
                    state_next = S_SIFT_RD;
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    res.load = 1'b1;
                    res.err = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_BLD_RD:
            begin
                ram_re = 1'b1;
                ram_raddr_a = bidx_reg;
                ram_raddr_b = bidx_reg;
                state_next = S_BLD_DAT;
            end
            S_BLD_DAT:
            begin
                cur_next = ram_rdata_a;
                pos_next = bidx_reg;
                state_next = S_SIFT_RD;
            end
            S_SIFT_RD:
            begin
                if (left_idx >= n_ext)
                begin
                    // hole is a leaf: park the moving word here
                    ram_we = 1'b1;
                    if (build_reg && (bidx_reg != '0))
                    begin
                        bidx_next = bidx_reg - AW'(1);
                        state_next = S_BLD_RD;
                    end
                    else
                    begin
                        build_next = 1'b0;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ram_re = 1'b1;
                    state_next = S_SIFT_CMP;
                end
            end
            S_SIFT_CMP:
            begin
                ram_we = 1'b1;
                if (swap)
                begin
                    // child moves up into the hole, hole moves down
                    ram_wdata = pick;
                    pos_next = pick_idx;
                    state_next = S_SIFT_RD;
                end
                else if (build_reg && (bidx_reg != '0))
                begin
                    bidx_next = bidx_reg - AW'(1);
                    state_next = S_BLD_RD;
                end
                else
                begin
                    build_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            build_reg <= 1'b0;
            remove_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            build_reg <= build_next;
            remove_reg <= remove_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        bidx_reg <= bidx_next;
        cur_reg <= cur_next;
        val_reg <= val_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_LISTS))
        else $error("heap count above capacity");

    a_load_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && action == ACT_LOAD && count_reg < CW'(MAX_LISTS))
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("load did not grow the heap");

    a_hole_descends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SIFT_CMP && swap) |=> pos_reg > $past(pos_reg))
        else $error("sift hole did not move down");

    a_error_only_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (res.load && res.err) |-> count_reg == '0)
        else $error("empty error with entries present");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import kmh_pkg::*;

    localparam int HEAP_DEPTH = DEF_MAX_LISTS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 600;

    typedef struct {
        logic signed [KEY_W-1:0] value;
        logic [SRC_W-1:0]        list;
        logic [LEFT_W-1:0]       left;
        logic                    err;
    } pop_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [1:0]              action;
    logic signed [KEY_W-1:0] item_value;
    logic [SRC_W-1:0]        item_list;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [KEY_W-1:0] min_value;
    logic [SRC_W-1:0]        min_list;
    logic [LEFT_W-1:0]       entries_left;
    logic                    empty_error;

    // predicted heap contents
    logic signed [KEY_W-1:0] heap_key [HEAP_DEPTH];
    logic [SRC_W-1:0]        heap_src [HEAP_DEPTH];
    int                      heap_count;
    pop_result_t             pending_pops [$];

    // elements still queued behind the head of each source list
    int unsigned list_tail [64];

    int  fail_count;
    int  sent_words;
    int  stall_left;
    int  cycle_count;
    bit  idle_en;

    kway_merge_min_heap #(
        .MAX_LISTS(HEAP_DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .item_value(item_value),
        .item_list(item_list),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .min_value(min_value),
        .min_list(min_list),
        .entries_left(entries_left),
        .empty_error(empty_error)
    );

    always #5 clk = ~clk;

    function automatic void heap_sink(input int start);
        int pos;
        int lchild;
        int rchild;
        int pick;
        bit done;
        logic signed [KEY_W-1:0] tk;
        logic [SRC_W-1:0] ts;
        pos = start;
        done = 1'b0;
        while (!done && pos < heap_count)
        begin
            lchild = 2 * pos + 1;
            rchild = lchild + 1;
            if (lchild >= heap_count)
                done = 1'b1;
            else
            begin
                // left child wins a tie
                if (rchild >= heap_count || !(heap_key[lchild] > heap_key[rchild]))
                    pick = lchild;
                else
                    pick = rchild;
                if (!(heap_key[pos] > heap_key[pick]))
                    done = 1'b1;
                else
                begin
                    tk = heap_key[pos];
                    ts = heap_src[pos];
                    heap_key[pos] = heap_key[pick];
                    heap_src[pos] = heap_src[pick];
                    heap_key[pick] = tk;
                    heap_src[pick] = ts;
                    pos = pick;
                end
            end
        end
    endfunction

    function automatic void predict_word(input logic [1:0] act,
                                         input logic signed [KEY_W-1:0] val,
                                         input logic [SRC_W-1:0] lst);
        pop_result_t res;
        case (act)
            ACT_LOAD:
            begin
                if (heap_count < HEAP_DEPTH)
                begin
                    heap_key[heap_count] = val;
                    heap_src[heap_count] = lst;
                    heap_count++;
                end
            end
            ACT_BUILD:
            begin
                for (int i = heap_count / 2 - 1; i >= 0; i--)
                    heap_sink(i);
            end
            default:
            begin
                if (heap_count == 0)
                begin
                    res.value = '0;
                    res.list = '0;
                    res.left = '0;
                    res.err = 1'b1;
                end
                else
                begin
                    res.value = heap_key[0];
                    res.list = heap_src[0];
                    if (act == ACT_REPLACE)
                        heap_key[0] = val;
                    else
                    begin
                        heap_count--;
                        heap_key[0] = heap_key[heap_count];
                        heap_src[0] = heap_src[heap_count];
                    end
                    if (heap_count > 1)
                        heap_sink(0);
                    res.left = LEFT_W'(heap_count);
                    res.err = 1'b0;
                end
                pending_pops.insert(pending_pops.size(), res);
            end
        endcase
    endfunction

    // entered and left at a falling edge; valid stays high into the next word
    task automatic send_word(input logic [1:0] act,
                             input logic signed [KEY_W-1:0] val,
                             input logic [SRC_W-1:0] lst);
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        item_value <= val;
        item_list <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_word(act, val, lst);
        sent_words++;
        @(negedge clk);
    endtask

    task automatic send_noise();
        send_word(2'($urandom_range(0, 3)), $urandom, SRC_W'($urandom_range(0, 63)));
    endtask

    // load heads of sorted lists, order the heap, then pop until it is empty
    task automatic run_merge(input int heads, input int overflow, input bit narrow);
        logic [SRC_W-1:0] id;
        logic signed [KEY_W-1:0] key;
        longint next_key;
        for (int i = 0; i < heads + overflow; i++)
        begin
            id = SRC_W'($urandom_range(0, 63));
            if (narrow)
                key = $urandom_range(0, 7);
            else
                key = $urandom;
            list_tail[id] = (heads > 16) ? $urandom_range(0, 1) : $urandom_range(0, 4);
            send_word(ACT_LOAD, key, id);
        end
        if ($urandom_range(0, 5) == 0)
            send_noise();
        send_word(ACT_BUILD, $urandom, SRC_W'($urandom_range(0, 63)));
        while (heap_count > 0)
        begin
            if ($urandom_range(0, 19) == 0)
                send_noise();
            else
            begin
                id = heap_src[0];
                if (list_tail[id] > 0)
                begin
                    list_tail[id]--;
                    next_key = longint'(heap_key[0]) +
                               (narrow ? $urandom_range(0, 2) : $urandom_range(0, 1000));
                    if (next_key > 64'sd2147483647)
                        next_key = 64'sd2147483647;
                    send_word(ACT_REPLACE, next_key[KEY_W-1:0],
                              SRC_W'($urandom_range(0, 63)));
                end
                else
                    send_word(ACT_REMOVE, $urandom, SRC_W'($urandom_range(0, 63)));
            end
        end
        if ($urandom_range(0, 3) == 0)
            send_word(ACT_REMOVE, $urandom, SRC_W'($urandom_range(0, 63)));
    endtask

    task automatic test_empty_pops();
        send_word(ACT_REPLACE, 32'sh7fffffff, 6'd63);
        send_word(ACT_REMOVE, 32'sh80000000, 6'd63);
    endtask

    task automatic test_key_extremes();
        send_word(ACT_LOAD, 32'sh7fffffff, 6'd63);
        send_word(ACT_LOAD, 32'sh80000000, 6'd0);
        send_word(ACT_LOAD, 32'sd0, 6'd42);
        send_word(ACT_LOAD, -32'sd1, 6'd21);
        send_word(ACT_LOAD, 32'sh80000000, 6'd5);
        send_word(ACT_BUILD, 32'sd0, 6'd0);
        // replacement keeps the root's list whatever item_list says
        send_word(ACT_REPLACE, 32'sh7fffffff, 6'd63);
        repeat (5)
            send_word(ACT_REMOVE, 32'sh55555555, 6'd42);
    endtask

    task automatic test_tie_order();
        send_word(ACT_LOAD, 32'sd7, 6'd1);
        send_word(ACT_LOAD, 32'sd7, 6'd2);
        send_word(ACT_LOAD, 32'sd7, 6'd3);
        send_word(ACT_BUILD, 32'sd0, 6'd0);
        repeat (3)
            send_word(ACT_REMOVE, 32'sd0, 6'd0);
    endtask

    task automatic test_load_after_build();
        send_word(ACT_LOAD, 32'sd10, 6'd4);
        send_word(ACT_BUILD, 32'sd0, 6'd0);
        // appended unsorted, then popped once before ordering again
        send_word(ACT_LOAD, -32'sd5, 6'd11);
        send_word(ACT_REPLACE, 32'sd30, 6'd0);
        send_word(ACT_BUILD, 32'sd0, 6'd0);
        repeat (2)
            send_word(ACT_REMOVE, 32'sd0, 6'd0);
    endtask

    task automatic test_full_heap();
        run_merge(HEAP_DEPTH, 3, 1'b0);
    endtask

    task automatic test_random_merges(input int stop_at);
        while (sent_words < stop_at)
        begin
            if ($urandom_range(0, 15) == 0)
                run_merge($urandom_range(13, 40), 0, 1'b0);
            else
                run_merge($urandom_range(1, 12), 0, $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic test_back_to_back(input int words);
        int stop_at;
        stop_at = sent_words + words;
        idle_en = 1'b0;
        while (sent_words < stop_at)
            run_merge($urandom_range(1, 12), 0, $urandom_range(0, 3) == 0);
    endtask

    // output side backpressure in random bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 7) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : result_check
        pop_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pops.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected word: value %0d list %0d left %0d err %0b",
                             min_value, min_list, entries_left, empty_error);
            end
            else
            begin
                want = pending_pops.pop_front();
                if (min_value !== want.value || min_list !== want.list ||
                    entries_left !== want.left || empty_error !== want.err)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                 want.value, want.list, want.left, want.err,
                                 min_value, min_list, entries_left, empty_error);
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_LOAD;
        item_value = '0;
        item_list = '0;
        out_stall = 1'b0;
        stall_left = 0;
        fail_count = 0;
        sent_words = 0;
        heap_count = 0;
        idle_en = 1'b1;
        foreach (list_tail[i])
            list_tail[i] = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_pops();
        test_key_extremes();
        test_tie_order();
        test_load_after_build();
        test_full_heap();
        test_random_merges(340);
        test_back_to_back(60);

        in_valid <= 1'b0;
        while (pending_pops.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
